/* hdl/fqt_pkg.sv */
// Shared types, constants and helpers for the frame quarter-turn rotator.
package fqt_pkg;

	// Frame store geometry
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int OCNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// Configuration port
	localparam int SIZE_REG_W = 9;
	localparam int CFG_DATA_W = SIZE_REG_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TURNS = 2'd2;

	localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 9'd256;

	// Request and status codes
	localparam logic REQ_LOAD       = 1'b0;
	localparam logic REQ_FETCH      = 1'b1;
	localparam logic ST_OK          = 1'b0;
	localparam logic ST_NOT_READY   = 1'b1;

	// Clockwise rotation codes
	localparam logic [1:0] TURN_0   = 2'd0;
	localparam logic [1:0] TURN_90  = 2'd1;
	localparam logic [1:0] TURN_180 = 2'd2;
	localparam logic [1:0] TURN_270 = 2'd3;

	localparam int PIXEL_W = 24;

	typedef struct packed {
		logic       req_type;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} fqt_req_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       row_end;
		logic       frame_end;
		logic       status;
	} fqt_rsp_t;

	// Store access and result flags for the request on the input port
	typedef struct packed {
		logic               we;
		logic               re;
		logic [ADDR_W-1:0]  addr;
		logic [PIXEL_W-1:0] wdata;
		logic               row_end;
		logic               frame_end;
		logic               not_ready;
	} fqt_access_t;

	// Size register to effective size: zero acts as one, above max acts as max
	function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v,
			input int maxv);
		logic [31:0] vx;
		begin
			vx = 32'(v);
			if (vx == 32'd0)
				return DIM_W'(1);
			else if (vx > 32'(maxv))
				return DIM_W'(maxv);
			else
				return DIM_W'(vx);
		end
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col);
	endfunction

endpackage

/* hdl/frame_quarter_turn_rotator.sv */
// Top level of the frame quarter-turn rotator: request stage and result register.
//
// Load requests (req_type 0) write one RGB pixel each, in row-major order, into a
// 256 x 256 frame store; loads beyond frame_width x frame_height are dropped and give
// no result. Fetch requests (req_type 1) each give one result: the next pixel of the
// stored image turned clockwise by quarter_turns, in output row-major order, with
// row_end and frame_end flags. A fetch before the frame is fully loaded returns
// status not_ready with zero pixel and flags. After the frame_end pixel the store may
// be loaded again. Writing a size register restarts loading; writing quarter_turns
// restarts fetching on the frame already held. Every request is at most one access to the
// single-port frame store, and a new request is taken every clock cycle unless
// req_stall holds it; a fetch result is registered in the store read, then in the
// result register, before it reaches rsp. Back-pressure on rsp stalls req only once
// both the read stage and the result register hold results. Config writes belong in
// idle periods with no request in flight; the block does not hold them off.
module frame_quarter_turn_rotator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fqt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fqt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  fqt_pkg::fqt_req_t              req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output fqt_pkg::fqt_rsp_t              rsp
);
	import fqt_pkg::*;

	fqt_access_t        acc;
	logic               take;
	logic [PIXEL_W-1:0] rdata;

	// read stage: one fetch in flight while the store read completes
	logic     valid_s1;
	logic     row_end_s1, frame_end_s1, not_ready_s1;
	logic     advance;
	fqt_rsp_t rsp_d;
	logic     rsp_valid_q;
	fqt_rsp_t rsp_q;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	fqt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.req       (req),
		.acc       (acc)
	);

	fqt_store u_store (
		.clk   (clk),
		.we    (acc.we),
		.re    (acc.re),
		.addr  (acc.addr),
		.wdata (acc.wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= (req.req_type == REQ_FETCH);
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_end_s1   <= acc.row_end;
			frame_end_s1 <= acc.frame_end;
			not_ready_s1 <= acc.not_ready;
		end
	end

	// not-ready result carries zero pixel and flags
	always_comb begin
		if (not_ready_s1) begin
			rsp_d = '0;
			rsp_d.status = ST_NOT_READY;
		end else begin
			rsp_d.out_red   = rdata[23:16];
			rsp_d.out_green = rdata[15:8];
			rsp_d.out_blue  = rdata[7:0];
			rsp_d.row_end   = row_end_s1;
			rsp_d.frame_end = frame_end_s1;
			rsp_d.status    = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (advance)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hdl/fqt_store.sv */
// Frame store: single-port synchronous RAM, registered read.
module fqt_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic                          re,
	input  logic [fqt_pkg::ADDR_W-1:0]    addr,
	input  logic [fqt_pkg::PIXEL_W-1:0]   wdata,
	output logic [fqt_pkg::PIXEL_W-1:0]   rdata
);
	import fqt_pkg::*;

	logic [PIXEL_W-1:0] mem [STORE_DEPTH];
	logic [PIXEL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (re)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/fqt_ctrl.sv */
// Config registers, load/output counters and store address generation.
module fqt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fqt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fqt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           take,
	input  fqt_pkg::fqt_req_t              req,
	output fqt_pkg::fqt_access_t           acc
);
	import fqt_pkg::*;

	logic [SIZE_REG_W-1:0] width_q, height_q;
	logic [1:0]            turns_q;
	logic [COL_W-1:0]      load_col_q;
	logic [ROW_W-1:0]      load_row_q;
	logic                  full_q;
	logic [OCNT_W-1:0]     out_row_q, out_col_q;

	logic [DIM_W-1:0] w, h, ow, oh, r, c, sr_x, sc_x;
	logic             ld_last_col, ld_last_row, rend, fend;
	logic             is_fetch;

	assign w  = clamp_size(width_q, MAX_WIDTH);
	assign h  = clamp_size(height_q, MAX_HEIGHT);
	assign ow = turns_q[0] ? h : w;
	assign oh = turns_q[0] ? w : h;
	assign r  = DIM_W'(out_row_q);
	assign c  = DIM_W'(out_col_q);

	assign ld_last_col = (DIM_W'(load_col_q) + DIM_W'(1)) >= w;
	assign ld_last_row = (DIM_W'(load_row_q) + DIM_W'(1)) >= h;
	assign rend        = (c + DIM_W'(1)) >= ow;
	assign fend        = rend && ((r + DIM_W'(1)) >= oh);
	assign is_fetch    = (req.req_type == REQ_FETCH);

	// source pixel of the current output position
	always_comb begin
		case (turns_q)
			TURN_0: begin
				sr_x = r;
				sc_x = c;
			end
			TURN_90: begin
				sr_x = h - DIM_W'(1) - c;
				sc_x = r;
			end
			TURN_180: begin
				sr_x = h - DIM_W'(1) - r;
				sc_x = w - DIM_W'(1) - c;
			end
			default: begin
				sr_x = c;
				sc_x = w - DIM_W'(1) - r;
			end
		endcase
	end

	always_comb begin
		acc.we        = take && !is_fetch && !full_q;
		acc.re        = take && is_fetch && full_q;
		acc.addr      = is_fetch ? store_addr(sr_x[ROW_W-1:0], sc_x[COL_W-1:0])
		                         : store_addr(load_row_q, load_col_q);
		acc.wdata     = {req.in_red, req.in_green, req.in_blue};
		acc.row_end   = full_q && rend;
		acc.frame_end = full_q && fend;
		acc.not_ready = !full_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= SIZE_RESET;
			height_q   <= SIZE_RESET;
			turns_q    <= TURN_0;
			load_col_q <= '0;
			load_row_q <= '0;
			full_q     <= 1'b0;
			out_row_q  <= '0;
			out_col_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
					if (cfg_index == REG_FRAME_WIDTH)
						width_q <= cfg_data[SIZE_REG_W-1:0];
					else
						height_q <= cfg_data[SIZE_REG_W-1:0];
					load_col_q <= '0;
					load_row_q <= '0;
					full_q     <= 1'b0;
					out_row_q  <= '0;
					out_col_q  <= '0;
				end
				REG_QUARTER_TURNS: begin
					turns_q   <= cfg_data[1:0];
					out_row_q <= '0;
					out_col_q <= '0;
				end
				default: ;
			endcase
		end else if (acc.we) begin
			if (ld_last_col) begin
				load_col_q <= '0;
				if (ld_last_row) begin
					load_row_q <= '0;
					full_q     <= 1'b1;
				end else begin
					load_row_q <= load_row_q + ROW_W'(1);
				end
			end else begin
				load_col_q <= load_col_q + COL_W'(1);
			end
		end else if (acc.re) begin
			if (fend) begin
				// frame delivered: store free for the next load
				full_q    <= 1'b0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else if (rend) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + OCNT_W'(1);
			end else begin
				out_col_q <= out_col_q + OCNT_W'(1);
			end
		end
	end

endmodule

/* tb/tb_frame_quarter_turn_rotator.sv */
// Self-checking testbench for the frame quarter-turn rotator: random frames, turns and stalls.
module tb_frame_quarter_turn_rotator;
	import fqt_pkg::*;

	// Unused slot of the two-bit register index; writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int unsigned ITEM_GOAL     = 1500;
	localparam int unsigned SETTLE_CYCLES = 6;       // result passes the read stage and result register
	localparam int unsigned CYCLE_LIMIT   = 500_000;

	// Corner values for the channels in the opening frame
	localparam logic [PIXEL_W-1:0] CORNER_PIXELS [6] = '{
		24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hA55AC3
	};
	// Size register values at and beyond the edges: zero acts as one, above 256 as 256
	localparam logic [SIZE_REG_W-1:0] EDGE_SIZES [4] = '{9'd0, 9'd256, 9'd257, 9'd511};

	// Mirror of the rotator: frame copy, load and fetch positions, registers,
	// and the pixels still owed to the response side.
	class rotated_frame_model;
		bit [PIXEL_W-1:0]    frame_copy [STORE_DEPTH];
		int unsigned         load_row, load_col, out_row, out_col;
		bit                  frame_full;
		logic [SIZE_REG_W-1:0] width_reg, height_reg;
		logic [1:0]          turns;
		fqt_rsp_t            pending_pixels [$];
		int unsigned         items_noted;
		int unsigned         mismatches;

		function new();
			width_reg  = SIZE_RESET;
			height_reg = SIZE_RESET;
			turns      = TURN_0;
			restart();
		endfunction

		function void restart();
			load_row   = 0;
			load_col   = 0;
			frame_full = 1'b0;
			out_row    = 0;
			out_col    = 0;
		endfunction

		function int unsigned active_size(logic [SIZE_REG_W-1:0] v, int unsigned limit);
			int unsigned vx;
			vx = 32'(v);
			if (vx == 0)
				return 1;
			if (vx > limit)
				return limit;
			return vx;
		endfunction

		function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_FRAME_WIDTH: begin
				width_reg = data;
				restart();
			end
			REG_FRAME_HEIGHT: begin
				height_reg = data;
				restart();
			end
			REG_QUARTER_TURNS: begin
				turns   = data[1:0];
				out_row = 0;
				out_col = 0;
			end
			default: ;
			endcase
		endfunction

		function void take_request(fqt_req_t r);
			int unsigned w, h, ow, oh, src_row, src_col;
			bit          row_last, frame_last;
			fqt_rsp_t    want;
			w = active_size(width_reg, MAX_WIDTH);
			h = active_size(height_reg, MAX_HEIGHT);
			if (r.req_type == REQ_LOAD) begin
				if (frame_full)
					return;
				items_noted++;
				frame_copy[load_row * MAX_WIDTH + load_col] = {r.in_red, r.in_green, r.in_blue};
				if (load_col + 1 >= w) begin
					load_col = 0;
					if (load_row + 1 >= h) begin
						load_row   = 0;
						frame_full = 1'b1;
					end else begin
						load_row++;
					end
				end else begin
					load_col++;
				end
				return;
			end
			items_noted++;
			want = '0;
			if (!frame_full) begin
				want.status = ST_NOT_READY;
				pending_pixels.push_back(want);
				return;
			end
			ow = turns[0] ? h : w;
			oh = turns[0] ? w : h;
			case (turns)
			TURN_0: begin
				src_row = out_row;
				src_col = out_col;
			end
			TURN_90: begin
				src_row = h - 1 - out_col;
				src_col = out_row;
			end
			TURN_180: begin
				src_row = h - 1 - out_row;
				src_col = w - 1 - out_col;
			end
			default: begin
				src_row = out_col;
				src_col = w - 1 - out_row;
			end
			endcase
			{want.out_red, want.out_green, want.out_blue} =
				frame_copy[src_row * MAX_WIDTH + src_col];
			row_last       = (out_col + 1 >= ow);
			frame_last     = row_last && (out_row + 1 >= oh);
			want.row_end   = row_last;
			want.frame_end = frame_last;
			want.status    = ST_OK;
			pending_pixels.push_back(want);
			if (frame_last) begin
				restart();
			end else if (row_last) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_pixel(fqt_rsp_t got);
			fqt_rsp_t want;
			if (pending_pixels.size() == 0) begin
				$error("result with no request outstanding: %h", got);
				mismatches++;
				return;
			end
			want = pending_pixels.pop_front();
			compare_field("out_red", want.out_red, got.out_red);
			compare_field("out_green", want.out_green, got.out_green);
			compare_field("out_blue", want.out_blue, got.out_blue);
			compare_field("row_end", 8'(want.row_end), 8'(got.row_end));
			compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
			compare_field("status", 8'(want.status), 8'(got.status));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	fqt_req_t              req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	fqt_rsp_t              rsp;

	rotated_frame_model rotation = new();

	// Idle rates in percent, changed per phase by the stimulus
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycle_count   = 0;

	frame_quarter_turn_rotator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Everything that happens at an edge is booked here, in one process, so the
	// order of register writes, requests and results never depends on the scheduler.
	// Values are read as they stood just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				rotation.apply_register(cfg_index, cfg_data);
			if (req_valid && !req_stall)
				rotation.take_request(req);
			if (rsp_valid && !rsp_stall)
				rotation.check_pixel(rsp);
		end
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL frame_quarter_turn_rotator");
			$finish;
		end
	end

	function automatic fqt_req_t pixel_request(logic kind, logic [PIXEL_W-1:0] rgb);
		fqt_req_t r;
		r.req_type = kind;
		{r.in_red, r.in_green, r.in_blue} = rgb;
		return r;
	endfunction

	// Channel values are random on fetches too, where the block must ignore them
	function automatic fqt_req_t random_request(logic kind);
		return pixel_request(kind, PIXEL_W'($urandom));
	endfunction

	// Present one request, with random idle cycles ahead of it, and hold it until
	// taken. Valid stays high on return so back-to-back requests need no gap.
	task automatic send_request(input fqt_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Drop valid and wait until every owed pixel is back, then wait on through
	// SETTLE_CYCLES so a trailing load has left the pipeline before a register is touched.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (rotation.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the wait with write enable low keeps it from being lowered
	// and raised in the same step when writes follow each other.
	task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One frame: optional resize and new turn count, full load with stray early
	// fetches, then a full fetch pass. Some frames break off: the load is dropped
	// half way, or the fetch pass is cut and restarted by a fresh turn write.
	task automatic run_frame(input int unsigned frame_no);
		logic [SIZE_REG_W-1:0] w_reg, h_reg;
		int unsigned           shape, npix, cut, i;
		shape = $urandom_range(99);
		case (frame_no)
		0: begin
			w_reg = 9'd511;
			h_reg = 9'd0;
		end
		1: begin
			w_reg = 9'd0;
			h_reg = 9'd256;
		end
		default: begin
			if (shape < 6) begin
				w_reg = EDGE_SIZES[$urandom_range(3)];
				h_reg = SIZE_REG_W'($urandom_range(2));
				if ($urandom_range(1))
					{w_reg, h_reg} = {h_reg, w_reg};
			end else if (shape < 15) begin
				w_reg = SIZE_REG_W'($urandom_range(9, 16));
				h_reg = SIZE_REG_W'($urandom_range(1, 4));
			end else begin
				w_reg = SIZE_REG_W'($urandom_range(1, 8));
				h_reg = SIZE_REG_W'($urandom_range(1, 8));
			end
		end
		endcase

		drain_results();
		if (frame_no < 2 || $urandom_range(99) < 75) begin
			if ($urandom_range(1)) begin
				set_register(REG_FRAME_WIDTH, w_reg);
				set_register(REG_FRAME_HEIGHT, h_reg);
			end else begin
				set_register(REG_FRAME_HEIGHT, h_reg);
				set_register(REG_FRAME_WIDTH, w_reg);
			end
		end
		if ($urandom_range(99) < 10)
			set_register(REG_UNUSED, CFG_DATA_W'($urandom));
		if ($urandom_range(99) < 85)
			set_register(REG_QUARTER_TURNS, CFG_DATA_W'($urandom));

		npix = rotation.active_size(rotation.width_reg, MAX_WIDTH) *
			rotation.active_size(rotation.height_reg, MAX_HEIGHT);
		shape = $urandom_range(99);

		for (i = 0; i < npix; i++) begin
			if ($urandom_range(99) < 5)
				send_request(random_request(REQ_FETCH));
			send_request(random_request(REQ_LOAD));
			if (shape < 8 && i == npix / 2)
				return;
		end
		// loads past a full frame are dropped
		if ($urandom_range(99) < 25)
			repeat ($urandom_range(1, 3)) send_request(random_request(REQ_LOAD));

		if (shape < 20) begin
			cut = $urandom_range(npix - 1);
			repeat (cut) send_request(random_request(REQ_FETCH));
			drain_results();
			set_register(REG_QUARTER_TURNS, CFG_DATA_W'($urandom));
		end
		repeat (npix) begin
			if ($urandom_range(99) < 4)
				send_request(random_request(REQ_LOAD));
			send_request(random_request(REQ_FETCH));
		end
		// frame end frees the store, so one more fetch is not ready
		if ($urandom_range(99) < 15)
			send_request(random_request(REQ_FETCH));
	endtask

	initial begin
		int unsigned phase, frame_no, k;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 36;
		recv_idle_pct = 81;

		// Opening frame: fetch straight out of reset, a stray load at the reset
		// size, then a 2 x 3 frame turned once with corner channel values,
		// a load past the full frame, the full fetch pass and one fetch too many.
		send_request(pixel_request(REQ_FETCH, 24'hFFFFFF));
		send_request(pixel_request(REQ_LOAD, 24'h000000));
		drain_results();
		set_register(REG_FRAME_WIDTH, 9'd2);
		set_register(REG_FRAME_HEIGHT, 9'd3);
		set_register(REG_QUARTER_TURNS, CFG_DATA_W'(TURN_90));
		set_register(REG_UNUSED, 9'h1FF);
		for (k = 0; k < 6; k++)
			send_request(pixel_request(REQ_LOAD, CORNER_PIXELS[k]));
		send_request(pixel_request(REQ_LOAD, 24'h5A5A5A));
		repeat (6) send_request(random_request(REQ_FETCH));
		send_request(random_request(REQ_FETCH));

		// Random frames in three phases of idling: sender light and receiver
		// heavy, then the other way round, then flat out.
		frame_no = 0;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				send_idle_pct = 36;
				recv_idle_pct = 81;
			end
			1: begin
				send_idle_pct = 81;
				recv_idle_pct = 36;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			endcase
			while (rotation.items_noted < (phase + 1) * ITEM_GOAL / 3) begin
				run_frame(frame_no);
				frame_no++;
			end
		end

		drain_results();
		if (rotation.mismatches == 0 && rotation.pending_pixels.size() == 0)
			$display("PASS frame_quarter_turn_rotator");
		else
			$display("FAIL frame_quarter_turn_rotator");
		$finish;
	end

endmodule

/* sim.f */
hdl/fqt_pkg.sv
hdl/fqt_store.sv
hdl/fqt_ctrl.sv
hdl/frame_quarter_turn_rotator.sv
tb/tb_frame_quarter_turn_rotator.sv
